// ===== rtl/core/tgb_pkg.sv =====
`timescale 1ns / 1ps

package tgb_pkg;

   localparam int GLYPH_ROWS   = 7;
   localparam int GLYPH_COLS   = 5;
   localparam int GLYPH_DOTS   = GLYPH_ROWS * GLYPH_COLS;
   localparam int ADVANCE_DOTS = 6;
   localparam int LINE_DOTS    = 8;
   localparam int SCALE_BITS   = 5;
   localparam int COLOR_BITS   = 32;
   localparam int OUT_COORD_BITS = 16;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_X    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_Y    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GLYPH_SCALE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DRAW_COLOR  = 2'd3;

   typedef logic [GLYPH_DOTS-1:0] dot_mask_type;
   typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_rows_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       start_of_text;
   } req_type;

   typedef struct packed {
      logic signed [OUT_COORD_BITS-1:0] square_x;
      logic signed [OUT_COORD_BITS-1:0] square_y;
      logic [SCALE_BITS-1:0]            square_side;
      logic [COLOR_BITS-1:0]            fill_color;
      logic                             last_of_glyph;
   } rsp_type;

   function automatic glyph_rows_type font_rows(input logic [7:0] ch);
      glyph_rows_type rows;
      case (ch)
         8'h41: rows = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'h42: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         8'h43: rows = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         8'h44: rows = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         8'h45: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         8'h46: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'h47: rows = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
         8'h48: rows = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'h49: rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'h4A: rows = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
         8'h4B: rows = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         8'h4C: rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         8'h4D: rows = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         8'h4E: rows = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
         8'h4F: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'h50: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'h51: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
         8'h52: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         8'h53: rows = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'h54: rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         8'h55: rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'h56: rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         8'h57: rows = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         8'h58: rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
         8'h59: rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         8'h5A: rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         8'h30: rows = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         8'h31: rows = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'h32: rows = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         8'h33: rows = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'h34: rows = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         8'h35: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
         8'h36: rows = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         8'h37: rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         8'h38: rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         8'h39: rows = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
         8'h3A: rows = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
         8'h2D: rows = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         8'h2E: rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04};
         default: rows = '0;
      endcase
      return rows;
   endfunction

   // bit r*5+c set when dot (r, c) is lit; lowest bit is drawn first
   function automatic dot_mask_type glyph_mask(input logic [7:0] text_byte);
      logic [7:0]     ch;
      glyph_rows_type rows;
      dot_mask_type   m;
      ch = text_byte;
      if (ch inside {[8'h61:8'h7A]}) begin
         ch = ch - 8'h20;
      end
      rows = font_rows(ch);
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         for (int c = 0; c < GLYPH_COLS; c++) begin
            m[r*GLYPH_COLS+c] = rows[r][GLYPH_COLS-1-c];
         end
      end
      return m;
   endfunction

endpackage

// ===== rtl/core/tgb_front.sv =====
`timescale 1ns / 1ps

module tgb_front #(
   parameter int COORD_BITS = 16,
   parameter int MAX_SCALE  = 16,
   parameter int ENTRY_W    = tgb_pkg::GLYPH_DOTS + 2 * COORD_BITS
                              + tgb_pkg::SCALE_BITS + tgb_pkg::COLOR_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  tgb_pkg::req_type                    req_data,
   input  logic                                csr_write,
   input  logic [tgb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tgb_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output logic                                q_push,
   output logic [ENTRY_W-1:0]                  q_data,
   input  logic                                q_full
);

   localparam int WIDE = (COORD_BITS > tgb_pkg::OUT_COORD_BITS ?
                          COORD_BITS : tgb_pkg::OUT_COORD_BITS) + 2;
   localparam logic signed [WIDE-1:0] CMAX =
      WIDE'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [WIDE-1:0] CMIN = -CMAX - WIDE'(1);

   logic signed [15:0]               origin_x_ff;
   logic signed [15:0]               origin_y_ff;
   logic [tgb_pkg::SCALE_BITS-1:0]   scale_ff;
   logic [tgb_pkg::COLOR_BITS-1:0]   color_ff;
   logic signed [COORD_BITS-1:0]     cursor_col_ff, cursor_col_in;
   logic signed [COORD_BITS-1:0]     cursor_row_ff, cursor_row_in;

   logic                             accept;
   logic                             is_newline;
   logic [tgb_pkg::SCALE_BITS-1:0]   eff_scale;
   logic [7:0]                       advance;
   logic [7:0]                       line_step;
   logic signed [COORD_BITS-1:0]     org_col, org_row;
   logic signed [COORD_BITS-1:0]     cur_col, cur_row;
   tgb_pkg::dot_mask_type            mask;

   function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] r;
      if (v > CMAX) begin
         r = CMAX;
      end else if (v < CMIN) begin
         r = CMIN;
      end else begin
         r = v;
      end
      return r[COORD_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_ff    <= tgb_pkg::SCALE_BITS'(1);
         color_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            tgb_pkg::REG_ORIGIN_X:    origin_x_ff <= csr_data[15:0];
            tgb_pkg::REG_ORIGIN_Y:    origin_y_ff <= csr_data[15:0];
            tgb_pkg::REG_GLYPH_SCALE: scale_ff    <= csr_data[tgb_pkg::SCALE_BITS-1:0];
            tgb_pkg::REG_DRAW_COLOR:  color_ff    <= csr_data[tgb_pkg::COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (scale_ff == '0) begin
         eff_scale = tgb_pkg::SCALE_BITS'(1);
      end else if (7'(scale_ff) > 7'(MAX_SCALE)) begin
         eff_scale = tgb_pkg::SCALE_BITS'(MAX_SCALE);
      end else begin
         eff_scale = scale_ff;
      end
   end

   assign advance   = 8'(eff_scale) * 8'(tgb_pkg::ADVANCE_DOTS);
   assign line_step = 8'(eff_scale) * 8'(tgb_pkg::LINE_DOTS);

   assign org_col = sat(WIDE'(origin_x_ff));
   assign org_row = sat(WIDE'(origin_y_ff));
   assign cur_col = req_data.start_of_text ? org_col : cursor_col_ff;
   assign cur_row = req_data.start_of_text ? org_row : cursor_row_ff;

   assign is_newline = (req_data.text_byte == tgb_pkg::NEWLINE_CODE);
   assign mask       = tgb_pkg::glyph_mask(req_data.text_byte);

   always_comb begin
      if (is_newline) begin
         cursor_col_in = org_col;
         cursor_row_in = sat(WIDE'(cur_row) + WIDE'(line_step));
      end else begin
         cursor_col_in = sat(WIDE'(cur_col) + WIDE'(advance));
         cursor_row_in = cur_row;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else if (accept) begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   // blank glyphs and newlines only move the cursor
   assign q_push = accept && !is_newline && (mask != '0);
   assign q_data = {mask, cur_col, cur_row, eff_scale, color_ff};

endmodule

// ===== rtl/core/tgb_queue.sv =====
`timescale 1ns / 1ps

module tgb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/tgb_back.sv =====
`timescale 1ns / 1ps

module tgb_back #(
   parameter int COORD_BITS = 16,
   parameter int ENTRY_W    = tgb_pkg::GLYPH_DOTS + 2 * COORD_BITS
                              + tgb_pkg::SCALE_BITS + tgb_pkg::COLOR_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRY_W-1:0] q_data,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output tgb_pkg::rsp_type   rsp_data
);

   localparam int WIDE = (COORD_BITS > tgb_pkg::OUT_COORD_BITS ?
                          COORD_BITS : tgb_pkg::OUT_COORD_BITS) + 2;
   localparam logic signed [WIDE-1:0] CMAX =
      WIDE'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [WIDE-1:0] CMIN = -CMAX - WIDE'(1);

   localparam int COLOR_LO = 0;
   localparam int SCALE_LO = COLOR_LO + tgb_pkg::COLOR_BITS;
   localparam int ROW_LO   = SCALE_LO + tgb_pkg::SCALE_BITS;
   localparam int COL_LO   = ROW_LO + COORD_BITS;
   localparam int MASK_LO  = COL_LO + COORD_BITS;

   tgb_pkg::dot_mask_type            mask_ff, mask_in;
   logic signed [COORD_BITS-1:0]     col_ff;
   logic signed [COORD_BITS-1:0]     row_ff;
   logic [tgb_pkg::SCALE_BITS-1:0]   scale_ff;
   logic [tgb_pkg::COLOR_BITS-1:0]   color_ff;
   logic                             out_valid_ff, out_valid_in;
   tgb_pkg::rsp_type                 out_word_ff, out_word_in;

   tgb_pkg::dot_mask_type            low_bit;
   tgb_pkg::dot_mask_type            rest_mask;
   logic [2:0]                       dot_row, dot_col;
   logic [7:0]                       x_off, y_off;
   logic signed [COORD_BITS-1:0]     x_sat, y_sat;
   logic signed [WIDE-1:0]           x_wide, y_wide;
   logic                             busy, out_ready, emit, load;

   function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] r;
      if (v > CMAX) begin
         r = CMAX;
      end else if (v < CMIN) begin
         r = CMIN;
      end else begin
         r = v;
      end
      return r[COORD_BITS-1:0];
   endfunction

   assign busy      = (mask_ff != '0);
   assign out_ready = !out_valid_ff || rsp_pop;
   assign emit      = busy && out_ready;
   assign low_bit   = mask_ff & (~mask_ff + 1'b1);
   assign rest_mask = mask_ff & ~low_bit;
   assign load      = !q_empty && (!busy || (emit && rest_mask == '0));
   assign q_pop     = load;

   always_comb begin
      dot_row = '0;
      dot_col = '0;
      for (int k = 0; k < tgb_pkg::GLYPH_DOTS; k++) begin
         if (low_bit[k]) begin
            dot_row = 3'(k / tgb_pkg::GLYPH_COLS);
            dot_col = 3'(k % tgb_pkg::GLYPH_COLS);
         end
      end
   end

   assign x_off  = 8'(dot_col) * 8'(scale_ff);
   assign y_off  = 8'(dot_row) * 8'(scale_ff);
   assign x_sat  = sat(WIDE'(col_ff) + WIDE'(x_off));
   assign y_sat  = sat(WIDE'(row_ff) + WIDE'(y_off));
   assign x_wide = WIDE'(x_sat);
   assign y_wide = WIDE'(y_sat);

   always_comb begin
      out_word_in.square_x      = x_wide[tgb_pkg::OUT_COORD_BITS-1:0];
      out_word_in.square_y      = y_wide[tgb_pkg::OUT_COORD_BITS-1:0];
      out_word_in.square_side   = scale_ff;
      out_word_in.fill_color    = color_ff;
      out_word_in.last_of_glyph = (rest_mask == '0);
   end

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = q_data[MASK_LO +: tgb_pkg::GLYPH_DOTS];
      end else if (emit) begin
         mask_in = rest_mask;
      end
   end

   assign out_valid_in = emit || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff   <= q_data[COL_LO +: COORD_BITS];
         row_ff   <= q_data[ROW_LO +: COORD_BITS];
         scale_ff <= q_data[SCALE_LO +: tgb_pkg::SCALE_BITS];
         color_ff <= q_data[COLOR_LO +: tgb_pkg::COLOR_BITS];
      end
      if (emit) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

// ===== rtl/core/text_glyph_blitter_5x7_unit.sv =====
`timescale 1ns / 1ps
// 5x7 text glyph blitter.
// Request queue: push a word {text_byte, start_of_text} while req_full is low.
// Result queue: while rsp_empty is low, rsp_data holds one square fill command
// {square_x, square_y, square_side, fill_color, last_of_glyph}; pop takes it.
// CSR port: csr_write with csr_index 0..3 sets origin_x, origin_y, glyph_scale,
// draw_color; write only while no text is in flight.
// One request word per cycle is taken while req_full is low; the front updates
// the cursor in that cycle and queues lit glyphs. Unless the result stalls, the
// back emits one square per cycle; a glyph with n lit dots yields n squares
// (2 to 20 with this font). Newline and blank glyphs only move the cursor. An
// idle block's first square passes glyph queue, back mask, output register.
// A stalled result side fills the output register, the back's glyph mask and
// the two-entry glyph queue, then raises req_full; nothing is dropped.
// Reset clears the cursor and queues and sets origin 0, scale 1, color 0.
module text_glyph_blitter_5x7_unit #(
   parameter int COORD_BITS = 16,
   parameter int MAX_SCALE  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  tgb_pkg::req_type                    req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output tgb_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [tgb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tgb_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int ENTRY_W = tgb_pkg::GLYPH_DOTS + 2 * COORD_BITS
                            + tgb_pkg::SCALE_BITS + tgb_pkg::COLOR_BITS;

   logic               q_push, q_full, q_pop, q_empty;
   logic [ENTRY_W-1:0] q_in_data, q_out_data;

   tgb_front #(
      .COORD_BITS (COORD_BITS),
      .MAX_SCALE  (MAX_SCALE),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_push    (q_push),
      .q_data    (q_in_data),
      .q_full    (q_full)
   );

   tgb_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   tgb_back #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_out_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
